/* src/usr_pkg.sv */
// usr_pkg: shared constants, register indexes and types for the user similarity recommender.
// Depends on nothing; the interface and the top level use it.
`timescale 1ns / 1ps
package usr_pkg;
  localparam int MaxUsers = 16;
  localparam int MaxBooks = 16;
  localparam int UserW = $clog2(MaxUsers);
  localparam int BookW = $clog2(MaxBooks);
  localparam int StoreDepth = MaxUsers * MaxBooks;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int CntW = $clog2(MaxBooks * MaxBooks);

  localparam logic [2:0] RegNumUsers = 3'd0;
  localparam logic [2:0] RegNumBooks = 3'd4;

  typedef logic signed [4:0] rating_t;
  typedef logic [15:0] score_t;
endpackage

/* src/usr_if.sv */
// usr_if: valid/ready channel interfaces for the recommender.
// Depends on usr_pkg.
`timescale 1ns / 1ps
interface usr_rating_if (input logic clk);
  logic valid;
  logic ready;
  usr_pkg::rating_t rating;
  modport source (output valid, output rating, input ready);
  modport sink (input valid, input rating, output ready);
endinterface

interface usr_rec_if (input logic clk);
  logic valid;
  logic ready;
  logic [4:0] book_number;
  usr_pkg::score_t predicted_score;
  logic last;
  modport source (output valid, output book_number, output predicted_score, output last,
                  input ready);
  modport sink (input valid, input book_number, input predicted_score, input last,
                output ready);
endinterface

/* src/usr_divider.sv */
// usr_divider: shared restoring divider, one quotient bit per cycle, rounding half up.
// Depends on nothing but the timescale; used by the top level for its divides.
`timescale 1ns / 1ps
module usr_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] q;
  logic [32:0] rem;
  logic [32:0] trial;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;

  assign trial = {rem[31:0], q[47]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // add half the divisor up front for round half up
        q    <= dividend + {17'd0, divisor[31:1]};
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= 6'd47;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[47]};
          q   <= {q[46:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end
  assign quotient = q;
endmodule

/* src/user_similarity_recommender.sv */
// user_similarity_recommender: top level, loads the rating matrix and runs the recommender.
// Depends on usr_pkg, usr_if and usr_divider.
//
// channel    dir   handshake     payload
// in_ch      in    valid/ready   rating (5 bit signed)
// out_ch     out   valid/ready   book_number, predicted_score, last
// apb        in    psel/penable  num_users, num_books
//
// Loading takes one rating per cycle while in_ch.valid is high. After the last rating
// the block stops taking requests while a sequencer computes: each pair rated by both
// users costs selection and reads, a square root and a divide on the shared divider.
// Each result then costs a search over nb books; a stalled output holds the sequencer.
// Reset is synchronous and clears control state; the rating store is not cleared.
`timescale 1ns / 1ps
module user_similarity_recommender (
  input  logic        clk,
  input  logic        rst,
  usr_rating_if.sink  in_ch,
  usr_rec_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = usr_pkg::AddrW;
  localparam int UW = usr_pkg::UserW;
  localparam int BW = usr_pkg::BookW;

  typedef enum logic [4:0] {
    S_LOAD, S_U_INIT, S_PJ, S_PK, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_SQRT,
    S_TDIV, S_TWAIT, S_SDIV, S_SWAIT, S_B_INIT, S_BRD0, S_BRD1, S_BACC, S_BDIV,
    S_BWAIT, S_E_SCAN, S_E_OUT
  } state_t;

  state_t state;
  logic [4:0] num_users, num_books;
  logic [AW:0] load_pos;
  logic [4:0] nu, nb;
  logic [AW:0] total;

  // rating store, one write port and one registered read port
  logic [4:0] store [usr_pkg::StoreDepth];
  logic [AW-1:0] raddr;
  logic [4:0] rdata;

  logic [UW-1:0] ui;
  logic [BW-1:0] bj, bk;
  logic [4:0] a1, b1, a2;
  logic [29:0] sim_sum;
  logic [usr_pkg::CntW:0] pair_cnt;
  logic [15:0] sim [usr_pkg::MaxUsers];
  logic [15:0] pred [usr_pkg::MaxBooks];
  logic [usr_pkg::MaxBooks-1:0] mark;
  logic [4:0] pending;

  // square root unit state (digit by digit, 2 bits a step)
  logic [39:0] sq_x, sq_r, sq_b;

  logic [35:0] num_acc;
  logic [19:0] w_acc;

  logic [BW-1:0] scan_j, best;
  logic best_ok;

  logic        div_start, div_done;
  logic [47:0] div_n, div_q;
  logic [31:0] div_d;

  logic [4:0] d1, d2;
  logic [9:0] dd;
  logic in_fire, out_fire, cfg_wr;
  logic [16:0] q17;

  assign nu = (num_users < 5'd2) ? 5'd2 : (num_users > 5'(usr_pkg::MaxUsers)) ?
              5'(usr_pkg::MaxUsers) : num_users;
  assign nb = (num_books < 5'd1) ? 5'd1 : (num_books > 5'(usr_pkg::MaxBooks)) ?
              5'(usr_pkg::MaxBooks) : num_books;
  assign total = (AW+1)'(nu * nb);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr)
      usr_pkg::RegNumUsers: prdata = {27'd0, num_users};
      usr_pkg::RegNumBooks: prdata = {27'd0, num_books};
      default:              prdata = '0;
    endcase
  end

  assign in_ch.ready = (state == S_LOAD);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign d1 = (a1 > b1) ? a1 - b1 : b1 - a1;
  assign d2 = (a2 > rdata) ? a2 - rdata : rdata - a2;
  assign dd = 10'(d1 * d1) + 10'(d2 * d2);
  assign q17 = div_q[16:0];

  always_ff @(posedge clk) begin
    if (in_fire) store[load_pos[AW-1:0]] <= in_ch.rating;
    rdata <= store[raddr];
  end

  usr_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      num_users <= 5'd16;
      num_books <= 5'd16;
      load_pos <= '0;
      mark <= '0;
      out_ch.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_wr && paddr == usr_pkg::RegNumUsers) begin
        num_users <= pwdata[4:0];
        load_pos <= '0;
      end else if (cfg_wr && paddr == usr_pkg::RegNumBooks) begin
        num_books <= pwdata[4:0];
        load_pos <= '0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (load_pos + 1'b1 >= total) begin
              load_pos <= '0;
              ui <= UW'(1);
              state <= S_U_INIT;
            end else begin
              load_pos <= load_pos + 1'b1;
            end
          end
        end
        S_U_INIT: begin
          sim_sum <= '0; pair_cnt <= '0; bj <= '0; bk <= '0;
          state <= S_PJ;
        end
        S_PJ: begin
          // next pair j<k, or finish the user
          if (32'(bk) + 1 < 32'(nb) && bk >= bj) begin
            bk <= bk + 1'b1;
            state <= S_RD0;
          end else if (32'(bj) + 2 < 32'(nb)) begin
            bj <= bj + 1'b1;
            bk <= bj + 1'b1;
            state <= S_PJ;
          end else if (pair_cnt == '0) begin
            sim[ui] <= '0;
            state <= S_SWAIT;
          end else begin
            div_n <= 48'(sim_sum);
            div_d <= 32'(pair_cnt);
            div_start <= 1'b1;
            state <= S_SDIV;
          end
        end
        S_RD0: begin raddr <= AW'(bj); state <= S_RD1; end
        S_RD1: begin raddr <= AW'(32'(ui) * 32'(nb) + 32'(bj)); state <= S_RD2; end
        S_RD2: begin a1 <= rdata; raddr <= AW'(bk); state <= S_RD3; end
        S_RD3: begin
          b1 <= rdata;
          raddr <= AW'(32'(ui) * 32'(nb) + 32'(bk));
          state <= S_RD4;
        end
        S_RD4: begin a2 <= rdata; state <= S_PK; end
        S_PK: begin
          if (a1[4] || b1[4] || a2[4] || rdata[4]) begin
            state <= S_PJ;
          end else begin
            sq_x <= {dd, 24'd0} >> 0;
            sq_r <= '0;
            sq_b <= 40'd1 << 38;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_b == '0) begin
            div_n <= 48'd1 << 28;
            div_d <= 32'd4096 + 32'(sq_r);
            div_start <= 1'b1;
            state <= S_TDIV;
          end else begin
            if (sq_x >= sq_r + sq_b) begin
              sq_x <= sq_x - (sq_r + sq_b);
              sq_r <= (sq_r >> 1) + sq_b;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_b <= sq_b >> 2;
          end
        end
        S_TDIV: state <= S_TWAIT;
        S_TWAIT: if (div_done) begin
          sim_sum <= sim_sum + 30'(q17);
          pair_cnt <= pair_cnt + 1'b1;
          state <= S_PJ;
        end
        S_SDIV: state <= S_SWAIT;
        S_SWAIT: begin
          if (pair_cnt == '0 || div_done) begin
            if (pair_cnt != '0)
              sim[ui] <= (div_q > 48'd65535) ? 16'hFFFF : div_q[15:0];
            if (32'(ui) + 1 < 32'(nu)) begin
              ui <= ui + 1'b1;
              state <= S_U_INIT;
            end else begin
              bj <= '0;
              pending <= '0;
              state <= S_B_INIT;
            end
          end
        end
        S_B_INIT: begin
          raddr <= AW'(bj);
          num_acc <= '0; w_acc <= '0; ui <= UW'(1);
          state <= S_BRD0;
        end
        S_BRD0: state <= S_BRD1;
        S_BRD1: begin
          if (!rdata[4]) begin
            mark[bj] <= 1'b1;
            state <= S_BDIV;
            pred[bj] <= pred[bj];
            bk <= '1;
          end else begin
            mark[bj] <= 1'b0;
            pending <= pending + 1'b1;
            raddr <= AW'(32'(ui) * 32'(nb) + 32'(bj));
            bk <= '0;
            state <= S_BACC;
          end
        end
        S_BACC: begin
          // registered read, then accumulate; bk toggles phase
          if (bk == '0) begin
            bk <= BW'(1);
          end else begin
            if (!rdata[4]) begin
              num_acc <= num_acc + 36'(sim[ui] * rdata[3:0]);
              w_acc <= w_acc + 20'(sim[ui]);
            end
            if (32'(ui) + 1 < 32'(nu)) begin
              ui <= ui + 1'b1;
              raddr <= AW'(32'(ui + 1'b1) * 32'(nb) + 32'(bj));
              bk <= '0;
            end else begin
              bk <= '0;
              state <= S_BDIV;
            end
          end
        end
        S_BDIV: begin
          if (bk == '1) begin
            state <= S_BWAIT;
          end else if (w_acc == '0) begin
            pred[bj] <= '0;
            bk <= '1;
            state <= S_BWAIT;
          end else begin
            div_n <= {num_acc, 12'd0};
            div_d <= 32'(w_acc);
            div_start <= 1'b1;
            bk <= BW'(1);
            state <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (bk == '1 || div_done) begin
            if (bk != '1)
              pred[bj] <= (div_q > 48'd65535) ? 16'hFFFF : div_q[15:0];
            if (32'(bj) + 1 < 32'(nb)) begin
              bj <= bj + 1'b1;
              state <= S_B_INIT;
            end else begin
              scan_j <= '0; best_ok <= 1'b0;
              state <= S_E_SCAN;
            end
          end
        end
        S_E_SCAN: begin
          if (pending == '0) begin
            state <= S_LOAD;
          end else begin
            if (!mark[scan_j] && (!best_ok || pred[scan_j] > pred[best])) begin
              best <= scan_j;
              best_ok <= 1'b1;
            end
            if (32'(scan_j) + 1 < 32'(nb)) begin
              scan_j <= scan_j + 1'b1;
            end else begin
              state <= S_E_OUT;
            end
          end
        end
        S_E_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.book_number <= 5'(best) + 5'd1;
            out_ch.predicted_score <= pred[best];
            out_ch.last <= (pending == 5'd1);
            mark[best] <= 1'b1;
          end else if (out_fire) begin
            out_ch.valid <= 1'b0;
            pending <= pending - 1'b1;
            scan_j <= '0; best_ok <= 1'b0;
            state <= S_E_SCAN;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

/* src/usr_checker.sv */
// usr_checker: port-level checks on the recommender, bound to the top level.
// Depends on nothing but the top level that it is bound to.
`timescale 1ns / 1ps
module usr_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [4:0] out_book
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while a result is pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_book))
    else $error("result dropped under stall");
  a_book_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_book != 5'd0) else $error("book number zero");
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid) else $error("result after last");
endmodule

bind user_similarity_recommender usr_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
  .out_book(out_ch.book_number)
);
